// ----- design/a85d_pkg.sv -----
// ----------------------------------------------------------------------------
// a85d_pkg: shared types and constants for the ASCII85 decoder
// Holds the channel payload structs, the result kinds and the work entry
// that travels from the character front end to the byte back end.
// ----------------------------------------------------------------------------
package a85d_pkg;

   localparam int GROUP_W  = 26;   // holds a partial group, below 85^4
   localparam int ACC_W    = 33;   // holds a full group, below 85^5
   localparam int PROD_W   = 46;   // partial group times a padding factor

   localparam logic [7:0] CHAR_BANG  = 8'h21;  // '!'
   localparam logic [7:0] CHAR_U     = 8'h75;  // 'u'
   localparam logic [7:0] CHAR_Z     = 8'h7A;  // 'z'
   localparam logic [7:0] CHAR_TILDE = 8'h7E;  // '~'
   localparam logic [7:0] CHAR_GT    = 8'h3E;  // '>'
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   localparam logic [6:0]  DIGIT_BASE = 7'd85;
   localparam logic [19:0] PAD_MUL_2  = 20'd614125;  // 85^3
   localparam logic [19:0] PAD_MUL_3  = 20'd7225;    // 85^2
   localparam logic [19:0] PAD_MUL_4  = 20'd85;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef struct packed {
      logic [7:0] in_char;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic       last_of_run;
   } rsp_type;

   // One decoded character's worth of results: bytes 0..last_idx of word,
   // big-endian, or a single marker/error result.
   typedef struct packed {
      kind_type    kind;
      logic [31:0] word;
      logic [1:0]  last_idx;
   } work_type;

endpackage

// ----- design/a85d_front.sv -----
// ----------------------------------------------------------------------------
// a85d_front: character classifier and group accumulator
// Takes one character per cycle when accept is high, tracks group and stream
// state, and pushes a work entry for every character that gives results.
// ----------------------------------------------------------------------------
module a85d_front
   import a85d_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     accept,
   input  req_type  req,
   output logic     work_push,
   output work_type work
);

   logic [GROUP_W-1:0] group_ff, group_in;
   logic [2:0]         count_ff, count_in;
   logic               tilde_ff, tilde_in;
   logic               done_ff, done_in;
   logic               error_ff, error_in;

   logic [7:0]         c;
   logic               is_ws;
   logic               is_digit;
   logic [6:0]         digit;
   logic [ACC_W-1:0]   acc;
   logic [19:0]        pad_mul;
   logic [PROD_W-1:0]  padded;
   logic               pad_ovf;
   logic               err_now;

   always_comb begin
      c        = req.in_char;
      is_ws    = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
      is_digit = (c >= CHAR_BANG) && (c <= CHAR_U);
      digit    = 7'(c - CHAR_BANG);
      acc      = {{(ACC_W-GROUP_W){1'b0}}, group_ff} * ACC_W'(DIGIT_BASE)
                 + ACC_W'(digit);
      case (count_ff)
         3'd2:    pad_mul = PAD_MUL_2;
         3'd3:    pad_mul = PAD_MUL_3;
         default: pad_mul = PAD_MUL_4;
      endcase
      // pad with 'u' digits: g * 85^m + (85^m - 1)
      padded  = {{(PROD_W-GROUP_W){1'b0}}, group_ff} * PROD_W'(pad_mul)
                + PROD_W'(pad_mul) - PROD_W'(1);
      pad_ovf = |padded[PROD_W-1:32];
   end

   always_comb begin
      group_in  = group_ff;
      count_in  = count_ff;
      tilde_in  = tilde_ff;
      done_in   = done_ff;
      error_in  = error_ff;
      err_now   = 1'b0;
      work_push = 1'b0;
      work      = '{kind: KIND_DATA, word: 32'd0, last_idx: 2'd3};

      if (accept && !done_ff) begin
         if (error_ff) begin
            err_now = 1'b1;
         end else begin
            if (is_ws) begin
               // skip
            end else if (tilde_ff) begin
               if (c != CHAR_GT) begin
                  err_now = 1'b1;
               end else begin
                  tilde_in  = 1'b0;
                  done_in   = 1'b1;
                  work_push = 1'b1;
                  work      = '{kind: KIND_END, word: 32'd0, last_idx: 2'd0};
               end
            end else if (c == CHAR_TILDE) begin
               if (count_ff == 3'd1) begin
                  err_now = 1'b1;
               end else if (count_ff >= 3'd2 && pad_ovf) begin
                  err_now = 1'b1;
               end else begin
                  if (count_ff >= 3'd2) begin
                     work_push = 1'b1;
                     work = '{kind: KIND_DATA, word: padded[31:0],
                              last_idx: 2'(count_ff - 3'd2)};
                  end
                  group_in = '0;
                  count_in = 3'd0;
                  tilde_in = 1'b1;
               end
            end else if (c == CHAR_Z) begin
               if (count_ff != 3'd0) begin
                  err_now = 1'b1;
               end else begin
                  work_push = 1'b1;
                  work = '{kind: KIND_DATA, word: 32'd0, last_idx: 2'd3};
               end
            end else if (is_digit) begin
               if (count_ff == 3'd4) begin
                  group_in = '0;
                  count_in = 3'd0;
                  if (acc[ACC_W-1]) begin
                     err_now = 1'b1;
                  end else begin
                     work_push = 1'b1;
                     work = '{kind: KIND_DATA, word: acc[31:0], last_idx: 2'd3};
                  end
               end else begin
                  group_in = acc[GROUP_W-1:0];
                  count_in = count_ff + 3'd1;
               end
            end else begin
               err_now = 1'b1;
            end

            // stream ends without the end marker: drop data, report error
            if (req.end_of_input && !done_in) begin
               err_now = 1'b1;
            end
         end

         if (err_now) begin
            error_in  = 1'b1;
            tilde_in  = 1'b0;
            done_in   = done_ff;
            group_in  = '0;
            count_in  = 3'd0;
            work_push = 1'b1;
            work      = '{kind: KIND_ERROR, word: 32'd0, last_idx: 2'd0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff <= '0;
         count_ff <= 3'd0;
         tilde_ff <= 1'b0;
         done_ff  <= 1'b0;
         error_ff <= 1'b0;
      end else begin
         group_ff <= group_in;
         count_ff <= count_in;
         tilde_ff <= tilde_in;
         done_ff  <= done_in;
         error_ff <= error_in;
      end
   end

endmodule

// ----- design/a85d_queue.sv -----
// ----------------------------------------------------------------------------
// a85d_queue: two-entry work queue
// Decouples the character front end from the byte back end.
// ----------------------------------------------------------------------------
module a85d_queue
   import a85d_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   input  logic     pop,
   output work_type head,
   output logic     full,
   output logic     empty
);

   work_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   always_comb begin
      full      = (count_ff == 2'd2);
      empty     = (count_ff == 2'd0);
      head      = slot_ff[rd_ptr_ff];
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- design/a85d_back.sv -----
// ----------------------------------------------------------------------------
// a85d_back: result serializer
// Splits each work entry into byte results, big-endian, and holds the
// oldest result in an output register until it is taken.
// ----------------------------------------------------------------------------
module a85d_back
   import a85d_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  work_type head,
   input  logic     head_empty,
   output logic     head_pop,
   output rsp_type  rsp,
   output logic     rsp_valid,
   input  logic     rsp_pop
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic       load;
   logic       last;
   logic [7:0] sel_byte;

   always_comb begin
      case (idx_ff)
         2'd0:    sel_byte = head.word[31:24];
         2'd1:    sel_byte = head.word[23:16];
         2'd2:    sel_byte = head.word[15:8];
         default: sel_byte = head.word[7:0];
      endcase
      last     = (idx_ff == head.last_idx);
      load     = !head_empty && (!valid_ff || rsp_pop);
      head_pop = load && last;
      idx_in   = idx_ff;
      if (load) begin
         idx_in = last ? 2'd0 : idx_ff + 2'd1;
      end
      valid_in = load || (valid_ff && !rsp_pop);
      rsp_in   = rsp_ff;
      if (load) begin
         rsp_in = '{out_byte: sel_byte, kind: head.kind, last_of_run: last};
      end
      rsp       = rsp_ff;
      rsp_valid = valid_ff;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ----- design/ascii85_decoder.sv -----
// ----------------------------------------------------------------------------
// ascii85_decoder: streaming ASCII85 decoder
// Input queue side: req_push with req_data (one character and an
// end-of-input flag), taken at a clock edge with req_push high and
// req_full low. Result queue side: rsp_data holds the oldest result while
// rsp_empty is low; it is taken at an edge with rsp_pop high.
// Each result is a data byte, the end-of-data marker or an error.
// One character is taken per cycle while req_full is low. Whitespace and
// digits that do not close a group give no result; a full group or 'z'
// gives four bytes, which the byte serializer sends at one per cycle
// while the receiver takes them. A two-entry work queue between the front
// end and the serializer absorbs the difference between the two.
// With nothing queued ahead, the first result of a character is written
// to a work queue slot and then to the output register, which drives rsp_data.
// When the receiver stalls, the output register holds, the work queue
// fills and req_full rises; nothing is lost.
// Reset clears the group, the stream flags and all queued results.
// ----------------------------------------------------------------------------
module ascii85_decoder
   import a85d_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    rsp_empty,
   output rsp_type rsp_data,
   input  logic    rsp_pop
);

   logic     accept;
   logic     work_push;
   work_type work;
   work_type head;
   logic     head_pop;
   logic     head_empty;
   logic     rsp_valid;

   assign accept    = req_push && !req_full;
   assign rsp_empty = !rsp_valid;

   a85d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .work_push (work_push),
      .work      (work)
   );

   a85d_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (work_push),
      .push_data (work),
      .pop       (head_pop),
      .head      (head),
      .full      (req_full),
      .empty     (head_empty)
   );

   a85d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_empty (head_empty),
      .head_pop   (head_pop),
      .rsp        (rsp_data),
      .rsp_valid  (rsp_valid),
      .rsp_pop    (rsp_pop)
   );

endmodule
